// ===== rtl/i2cm_pkg.sv =====
`timescale 1ns / 1ps

package i2cm_pkg;

    // command codes carried in the low bits of an input beat
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

    // bus engine phases
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_S_LOWSDA = 4'd1,
        PH_LOW_DONE = 4'd2,
        PH_P_HIGH   = 4'd3,
        PH_P_REL    = 4'd4,
        PH_W_BIT    = 4'd5,
        PH_W_LOW    = 4'd6,
        PH_K_RISE   = 4'd7,
        PH_K_POLL   = 4'd8,
        PH_R_HIGH   = 4'd9,
        PH_R_SAMPLE = 4'd10,
        PH_A_SET    = 4'd11,
        PH_A_HIGH   = 4'd12
    } t_phase;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_DELAY_TICKS    = 1'b0,
        CFG_ACK_WAIT_LIMIT = 1'b1
    } t_cfg_idx;

    localparam int STREAM_W    = 16;
    localparam int CFG_DATA_W  = 8;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] DELAY_TICKS_RESET = 8'd1;
    localparam logic [7:0] ACK_LIMIT_RESET   = 8'd200;

    // one classified tick as it sits in the queue
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] write_data;
        logic       send_nack;
        logic       sda_in;
    } t_item;

    // configuration write bundle
    typedef struct packed {
        logic                  we;
        t_cfg_idx              index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

// ===== rtl/i2cm_front.sv =====
`timescale 1ns / 1ps

module i2cm_front (
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [i2cm_pkg::STREAM_W-1:0] s_axis_tdata,
    input  logic                          i_full,
    output logic                          o_push,
    output i2cm_pkg::t_item               o_item
);
    import i2cm_pkg::*;

    // accept whenever the queue has room
    assign s_axis_tready = ~i_full;
    assign o_push        = s_axis_tvalid & ~i_full;

    // classify the command, unknown codes become no-op
    always_comb begin
        o_item.write_data = s_axis_tdata[10:3];
        o_item.send_nack  = s_axis_tdata[11];
        o_item.sda_in     = s_axis_tdata[12];
        case (s_axis_tdata[2:0])
            CMD_START: o_item.cmd = CMD_START;
            CMD_STOP:  o_item.cmd = CMD_STOP;
            CMD_WRITE: o_item.cmd = CMD_WRITE;
            CMD_READ:  o_item.cmd = CMD_READ;
            default:   o_item.cmd = CMD_NONE;
        endcase
    end

endmodule

// ===== rtl/i2cm_queue.sv =====
`timescale 1ns / 1ps

module i2cm_queue #(
    parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  i2cm_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output i2cm_pkg::t_item o_item
);
    import i2cm_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/i2cm_engine.sv =====
`timescale 1ns / 1ps

module i2cm_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  i2cm_pkg::t_cfg_wr             i_cfg,
    input  logic                          i_empty,
    input  i2cm_pkg::t_item               i_item,
    output logic                          o_pop,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [i2cm_pkg::STREAM_W-1:0] m_axis_tdata
);
    import i2cm_pkg::*;

    logic [7:0] r_delay_ticks;
    logic [7:0] r_ack_limit;

    t_phase     r_phase,  n_phase;
    logic [3:0] r_bit_idx, n_bit_idx;
    logic [7:0] r_tick,   n_tick;
    logic [7:0] r_wait,   n_wait;
    logic [7:0] r_shift,  n_shift;
    logic       r_scl,    n_scl;
    logic       r_sda,    n_sda;
    logic       r_ack_fail, n_ack_fail;
    logic [7:0] r_rx_byte,  n_rx_byte;
    logic       r_ack_choice, n_ack_choice;

    logic                r_out_valid, n_out_valid;
    logic [STREAM_W-1:0] r_out_data,  n_out_data;

    logic       take;
    logic       done;
    logic [7:0] hold_ticks;
    logic [7:0] ack_lim;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_ticks <= DELAY_TICKS_RESET;
            r_ack_limit   <= ACK_LIMIT_RESET;
        end else if (i_cfg.we) begin
            case (i_cfg.index)
                CFG_DELAY_TICKS:    r_delay_ticks <= i_cfg.data;
                CFG_ACK_WAIT_LIMIT: r_ack_limit   <= i_cfg.data;
                default:            ;
            endcase
        end
    end

    // a zero register counts as one
    assign hold_ticks = (r_delay_ticks == 8'd0) ? 8'd0 : r_delay_ticks - 8'd1;
    assign ack_lim    = (r_ack_limit == 8'd0) ? 8'd1 : r_ack_limit;

    // pop a tick when the output slot is free or being drained
    assign take  = ~i_empty & (~r_out_valid | m_axis_tready);
    assign o_pop = take;

    // engine state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_idx    <= '0;
            r_tick       <= '0;
            r_wait       <= '0;
            r_shift      <= '0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_ack_fail   <= 1'b0;
            r_rx_byte    <= '0;
            r_ack_choice <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_bit_idx    <= n_bit_idx;
            r_tick       <= n_tick;
            r_wait       <= n_wait;
            r_shift      <= n_shift;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_ack_fail   <= n_ack_fail;
            r_rx_byte    <= n_rx_byte;
            r_ack_choice <= n_ack_choice;
            r_out_valid  <= n_out_valid;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    // one tick of the bus engine
    always_comb begin
        n_phase      = r_phase;
        n_bit_idx    = r_bit_idx;
        n_tick       = r_tick;
        n_wait       = r_wait;
        n_shift      = r_shift;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_ack_fail   = r_ack_fail;
        n_rx_byte    = r_rx_byte;
        n_ack_choice = r_ack_choice;
        done         = 1'b0;

        if (take) begin
            if (r_phase == PH_IDLE) begin
                // launch a new command
                case (i_item.cmd)
                    CMD_START: begin
                        n_sda = 1'b1; n_scl = 1'b1;
                        n_tick = hold_ticks; n_phase = PH_S_LOWSDA;
                    end
                    CMD_STOP: begin
                        n_scl = 1'b0; n_sda = 1'b0;
                        n_tick = hold_ticks; n_phase = PH_P_HIGH;
                    end
                    CMD_WRITE: begin
                        n_shift = i_item.write_data; n_bit_idx = 4'd8; n_scl = 1'b0;
                        n_tick = hold_ticks; n_phase = PH_W_BIT;
                    end
                    CMD_READ: begin
                        n_shift = '0; n_bit_idx = 4'd8;
                        n_ack_choice = i_item.send_nack; n_sda = 1'b1;
                        n_tick = hold_ticks; n_phase = PH_R_HIGH;
                    end
                    default: ;
                endcase
            end else if (r_tick != 8'd0) begin
                // hold pins for the rest of the delay
                n_tick = r_tick - 8'd1;
            end else begin
                n_tick = hold_ticks;
                case (r_phase)
                    PH_S_LOWSDA: begin
                        n_sda = 1'b0; n_phase = PH_LOW_DONE;
                    end
                    PH_LOW_DONE: begin
                        n_scl = 1'b0; n_tick = r_tick; n_phase = PH_IDLE; done = 1'b1;
                    end
                    PH_P_HIGH: begin
                        n_scl = 1'b1; n_phase = PH_P_REL;
                    end
                    PH_P_REL: begin
                        n_sda = 1'b1; n_tick = r_tick; n_phase = PH_IDLE; done = 1'b1;
                    end
                    PH_W_BIT: begin
                        n_sda = r_shift[7]; n_scl = 1'b1; n_phase = PH_W_LOW;
                    end
                    PH_W_LOW: begin
                        n_scl     = 1'b0;
                        n_shift   = {r_shift[6:0], 1'b0};
                        n_bit_idx = r_bit_idx - 4'd1;
                        n_phase   = (n_bit_idx != 4'd0) ? PH_W_BIT : PH_K_RISE;
                    end
                    PH_K_RISE: begin
                        n_sda = 1'b1; n_scl = 1'b1; n_wait = '0; n_phase = PH_K_POLL;
                    end
                    PH_K_POLL: begin
                        // poll for the slave ack once per delay
                        if (!i_item.sda_in) begin
                            n_scl = 1'b0; n_ack_fail = 1'b0; n_tick = r_tick;
                            n_phase = PH_IDLE; done = 1'b1;
                        end else begin
                            n_wait = r_wait + 8'd1;
                            if (n_wait >= ack_lim) begin
                                n_ack_fail = 1'b1; n_scl = 1'b0; n_tick = r_tick;
                                n_phase = PH_IDLE; done = 1'b1;
                            end
                        end
                    end
                    PH_R_HIGH: begin
                        n_scl = 1'b1; n_phase = PH_R_SAMPLE;
                    end
                    PH_R_SAMPLE: begin
                        n_shift   = {r_shift[6:0], i_item.sda_in};
                        n_bit_idx = r_bit_idx - 4'd1;
                        n_scl     = 1'b0;
                        n_phase   = (n_bit_idx != 4'd0) ? PH_R_HIGH : PH_A_SET;
                    end
                    PH_A_SET: begin
                        n_rx_byte = r_shift; n_sda = r_ack_choice; n_phase = PH_A_HIGH;
                    end
                    PH_A_HIGH: begin
                        n_scl = 1'b1; n_phase = PH_LOW_DONE;
                    end
                    default: begin
                        n_tick = r_tick; n_phase = PH_IDLE;
                    end
                endcase
            end
        end

        // output slot: load on a tick, clear when drained
        if (take) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end

        if (take) begin
            n_out_data = {3'b000, n_ack_fail, n_rx_byte, done,
                          (n_phase != PH_IDLE), ~n_sda, n_scl};
        end else begin
            n_out_data = r_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== rtl/i2c_bit_level_master_top.sv =====
`timescale 1ns / 1ps
// I2C master bus engine working one bus operation at a time.
// Slave stream: one beat is one time tick; it may carry a command (start, stop,
// write byte with ack check, read byte with ack or nack) that is taken only while
// the engine is idle, plus the sampled SDA level. Commands arriving while busy
// and unknown codes are ignored. Master stream: one result beat per input beat
// with the SCL level, SDA pull-down, busy and done flags, last read byte and nack.
// Configuration: write delay_ticks (index 0) or ack_wait_limit (index 1) with
// i_cfg_we; only while the stream is drained.
// A result leaves through the queue slot and then the engine output register.
// Throughput: one beat per cycle while the receiver does not stall, set by the
// single engine step that updates the state once per tick.
// A four-entry queue sits between the command decoder and the engine; when the
// receiver stalls the output register holds and the queue fills, then
// s_axis_tready drops until beats drain again.
// Reset (synchronous, active low): engine idle, SCL high, SDA released, read
// byte and nack cleared, delay_ticks 1, ack_wait_limit 200, queue empty.

module i2c_bit_level_master_top #(
    parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command 2:0, write_data 10:3, send_nack 11, sda_in 12, zero 15:13
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [i2cm_pkg::STREAM_W-1:0]   s_axis_tdata,
    // scl_out 0, sda_low 1, busy_res 2, done_res 3, read_data 11:4, nack_seen 12
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [i2cm_pkg::STREAM_W-1:0]   m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [0:0]                      i_cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import i2cm_pkg::*;

    t_item   push_item;
    t_item   pop_item;
    logic    push;
    logic    pop;
    logic    full;
    logic    empty;
    t_cfg_wr cfg;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = t_cfg_idx'(i_cfg_index);
    assign cfg.data  = i_cfg_wdata;

    i2cm_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_full        (full),
        .o_push        (push),
        .o_item        (push_item)
    );

    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (pop_item)
    );

    i2cm_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_empty       (empty),
        .i_item        (pop_item),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
